// ===== rtl/hcl_pkg.sv =====
// ----------------------------------------------------------------------------
// hcl_pkg
// Shared constants, codes and state types of the hash chain set lookup.
// ----------------------------------------------------------------------------
package hcl_pkg;

    localparam int KEY_W        = 31;
    localparam int BUCKETS_DEF  = 10;
    localparam int POOL_DEF     = 64;
    localparam int STEP_BITS    = 4;
    localparam int REDUCE_STEPS = (KEY_W + STEP_BITS - 1) / STEP_BITS;

    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_SEARCH  = 1'b1;
    localparam logic STAT_OK     = 1'b0;
    localparam logic STAT_FULL   = 1'b1;

    typedef enum logic [1:0] {
        F_IDLE,
        F_REDUCE,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_HEAD,
        B_WALK,
        B_RESP
    } back_state_t;

endpackage

// ===== rtl/hcl_ram.sv =====
// ----------------------------------------------------------------------------
// hcl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/hcl_front.sv =====
// ----------------------------------------------------------------------------
// hcl_front
// Accepts requests and computes the bucket of the key, four key bits a cycle.
// ----------------------------------------------------------------------------
module hcl_front #(
    parameter int BUCKETS = hcl_pkg::BUCKETS_DEF,
    parameter int BW      = $clog2(BUCKETS),
    parameter int QW      = 1 + hcl_pkg::KEY_W + BW
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     init_done,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     req_type,
    input  logic [hcl_pkg::KEY_W-1:0] key,
    output logic                     push_valid,
    input  logic                     push_ready,
    output logic [QW-1:0]            push_data
);

    localparam int PW = hcl_pkg::REDUCE_STEPS * hcl_pkg::STEP_BITS;
    localparam int CW = (hcl_pkg::REDUCE_STEPS > 1) ? $clog2(hcl_pkg::REDUCE_STEPS) : 1;
    localparam logic [BW:0]   BUCKETS_W = (BW + 1)'(BUCKETS);
    localparam logic [CW-1:0] LAST_STEP = CW'(hcl_pkg::REDUCE_STEPS - 1);

    hcl_pkg::front_state_t state_reg, state_next;

    logic                      req_reg;
    logic [hcl_pkg::KEY_W-1:0] key_reg;
    logic [PW-1:0]             shift_reg, shift_next;
    logic [BW-1:0]             rem_reg, rem_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [BW-1:0]             rem_step;
    logic                      accept;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        logic [BW:0] r;
        r = {1'b0, rem_reg};
        for (int i = 0; i < hcl_pkg::STEP_BITS; i++)
        begin
            r = {r[BW-1:0], shift_reg[PW-1-i]};
            if (r >= BUCKETS_W)
            begin
                r = r - BUCKETS_W;
            end
        end
        rem_step = r[BW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hcl_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    state_next = hcl_pkg::F_REDUCE;
                end
            end
            hcl_pkg::F_REDUCE:
            begin
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = hcl_pkg::F_PUSH;
                end
            end
            hcl_pkg::F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = hcl_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = hcl_pkg::F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        push_valid = 1'b0;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            hcl_pkg::F_IDLE:
            begin
                in_ready   = init_done;
                shift_next = {{(PW - hcl_pkg::KEY_W){1'b0}}, key};
                rem_next   = '0;
                cnt_next   = '0;
            end
            hcl_pkg::F_REDUCE:
            begin
                shift_next = shift_reg << hcl_pkg::STEP_BITS;
                rem_next   = rem_step;
                cnt_next   = cnt_reg + 1'b1;
            end
            hcl_pkg::F_PUSH:
            begin
                push_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hcl_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        if (accept)
        begin
            req_reg <= req_type;
            key_reg <= key;
        end
    end

    assign push_data = {req_reg, key_reg, rem_reg};

endmodule

// ===== rtl/hcl_queue.sv =====
// ----------------------------------------------------------------------------
// hcl_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module hcl_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/hcl_back.sv =====
// ----------------------------------------------------------------------------
// hcl_back
// Executes inserts and chain walks on the bucket head and node memories.
// ----------------------------------------------------------------------------
module hcl_back #(
    parameter int BUCKETS      = hcl_pkg::BUCKETS_DEF,
    parameter int POOL_ENTRIES = hcl_pkg::POOL_DEF,
    parameter int BW           = $clog2(BUCKETS),
    parameter int QW           = 1 + hcl_pkg::KEY_W + BW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  logic [QW-1:0] q_data,
    output logic          init_done,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          found,
    output logic          status
);

    localparam int KW = hcl_pkg::KEY_W;
    localparam int LW = $clog2(POOL_ENTRIES + 1);
    localparam int NW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam logic [LW-1:0] POOL_W      = LW'(POOL_ENTRIES);
    localparam logic [BW-1:0] LAST_BUCKET = BW'(BUCKETS - 1);

    hcl_pkg::back_state_t state_reg, state_next;

    logic [BW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          req_reg, req_next;
    logic [KW-1:0] key_reg, key_next;
    logic [BW-1:0] bucket_reg, bucket_next;
    logic [LW-1:0] used_reg, used_next;
    logic [LW-1:0] steps_reg, steps_next;
    logic          res_found_reg, res_found_next;
    logic          res_status_reg, res_status_next;
    logic          out_valid_reg, out_valid_next;
    logic          found_reg, found_next;
    logic          status_reg, status_next;

    logic          q_req;
    logic [KW-1:0] q_key;
    logic [BW-1:0] q_bucket;
    logic          pop;

    logic          head_wr_en;
    logic [BW-1:0] head_wr_addr;
    logic [LW-1:0] head_wr_data;
    logic          head_rd_en;
    logic [LW-1:0] head_rd_data;

    logic           node_wr_en;
    logic [KW+LW-1:0] node_wr_data;
    logic           node_rd_en;
    logic [NW-1:0]  node_rd_addr;
    logic [KW+LW-1:0] node_rd_data;
    logic [KW-1:0]  node_key;
    logic [LW-1:0]  node_link;
    logic [LW-1:0]  link_dec;
    logic [LW-1:0]  steps_inc;
    logic           out_free;

    assign q_req    = q_data[QW-1];
    assign q_key    = q_data[QW-2 -: KW];
    assign q_bucket = q_data[BW-1:0];
    assign pop      = q_valid && q_ready;

    assign node_key  = node_rd_data[KW+LW-1:LW];
    assign node_link = node_rd_data[LW-1:0];
    assign steps_inc = steps_reg + 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hcl_pkg::B_CLEAR:
            begin
                if (clr_cnt_reg == LAST_BUCKET)
                begin
                    state_next = hcl_pkg::B_IDLE;
                end
            end
            hcl_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_req == hcl_pkg::REQ_INSERT && used_reg == POOL_W)
                    begin
                        state_next = hcl_pkg::B_RESP;
                    end
                    else
                    begin
                        state_next = hcl_pkg::B_HEAD;
                    end
                end
            end
            hcl_pkg::B_HEAD:
            begin
                if (req_reg == hcl_pkg::REQ_INSERT || head_rd_data == '0
                    || head_rd_data > used_reg)
                begin
                    state_next = hcl_pkg::B_RESP;
                end
                else
                begin
                    state_next = hcl_pkg::B_WALK;
                end
            end
            hcl_pkg::B_WALK:
            begin
                if (node_key == key_reg || node_link == '0 || node_link > used_reg
                    || steps_inc >= used_reg)
                begin
                    state_next = hcl_pkg::B_RESP;
                end
            end
            hcl_pkg::B_RESP:
            begin
                if (out_free)
                begin
                    state_next = hcl_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = hcl_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_ready         = 1'b0;
        head_wr_en      = 1'b0;
        head_wr_addr    = bucket_reg;
        head_wr_data    = used_reg + 1'b1;
        head_rd_en      = 1'b0;
        node_wr_en      = 1'b0;
        node_wr_data    = {key_reg, head_rd_data};
        node_rd_en      = 1'b0;
        link_dec        = head_rd_data - 1'b1;
        clr_cnt_next    = clr_cnt_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        bucket_next     = bucket_reg;
        used_next       = used_reg;
        steps_next      = steps_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        found_next      = found_reg;
        status_next     = status_reg;
        case (state_reg)
            hcl_pkg::B_CLEAR:
            begin
                head_wr_en   = 1'b1;
                head_wr_addr = clr_cnt_reg;
                head_wr_data = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            hcl_pkg::B_IDLE:
            begin
                q_ready         = 1'b1;
                head_rd_en      = pop;
                req_next        = q_req;
                key_next        = q_key;
                bucket_next     = q_bucket;
                res_found_next  = 1'b0;
                res_status_next = (q_req == hcl_pkg::REQ_INSERT && used_reg == POOL_W)
                                  ? hcl_pkg::STAT_FULL : hcl_pkg::STAT_OK;
            end
            hcl_pkg::B_HEAD:
            begin
                if (req_reg == hcl_pkg::REQ_INSERT)
                begin
                    head_wr_en = 1'b1;
                    node_wr_en = 1'b1;
                    used_next  = used_reg + 1'b1;
                end
                else
                begin
                    node_rd_en = (head_rd_data != '0) && (head_rd_data <= used_reg);
                    steps_next = '0;
                end
            end
            hcl_pkg::B_WALK:
            begin
                link_dec = node_link - 1'b1;
                if (node_key == key_reg)
                begin
                    res_found_next = 1'b1;
                end
                else
                begin
                    node_rd_en = (node_link != '0) && (node_link <= used_reg)
                                 && (steps_inc < used_reg);
                    steps_next = steps_inc;
                end
            end
            hcl_pkg::B_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = res_found_reg;
                    status_next    = res_status_reg;
                end
            end
            default:
            begin
                q_ready = 1'b0;
            end
        endcase
    end

    assign node_rd_addr = link_dec[NW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hcl_pkg::B_CLEAR;
            clr_cnt_reg   <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        key_reg        <= key_next;
        bucket_reg     <= bucket_next;
        steps_reg      <= steps_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
    end

    hcl_ram #(
        .WIDTH (LW),
        .DEPTH (BUCKETS)
    ) u_head_ram (
        .clk     (clk),
        .wr_en   (head_wr_en),
        .wr_addr (head_wr_addr),
        .wr_data (head_wr_data),
        .rd_en   (head_rd_en),
        .rd_addr (q_bucket),
        .rd_data (head_rd_data)
    );

    hcl_ram #(
        .WIDTH (KW + LW),
        .DEPTH (POOL_ENTRIES)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (node_wr_en),
        .wr_addr (used_reg[NW-1:0]),
        .wr_data (node_wr_data),
        .rd_en   (node_rd_en),
        .rd_addr (node_rd_addr),
        .rd_data (node_rd_data)
    );

    assign init_done = (state_reg != hcl_pkg::B_CLEAR);
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign status    = status_reg;

endmodule

// ===== rtl/hash_chain_set_lookup.sv =====
// ----------------------------------------------------------------------------
// hash_chain_set_lookup
// Hash set with separate chaining over a fixed pool of nodes.
// ----------------------------------------------------------------------------
// Each request inserts a key or searches for it, and gives exactly one result.
// The front takes a request and reduces the key modulo BUCKETS four bits a
// cycle, and takes no new request until it has pushed the last one on. A
// two-entry queue then hands it to the back, which reads the bucket head and
// writes the node for an insert, answers an insert dropped because the pool is
// full without writing, and walks n chain nodes on a search, one node memory read per node. The
// sustained rate is the slower of the two parts. After reset the bucket head
// memory is cleared in a pass over all BUCKETS entries, during which no request is
// taken. An insert into a full pool changes nothing and reports status 1.
module hash_chain_set_lookup #(
    parameter int BUCKETS      = hcl_pkg::BUCKETS_DEF,
    parameter int POOL_ENTRIES = hcl_pkg::POOL_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      req_type,
    input  logic [hcl_pkg::KEY_W-1:0] key,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      found,
    output logic                      status
);

    localparam int BW = $clog2(BUCKETS);
    localparam int QW = 1 + hcl_pkg::KEY_W + BW;

    logic          init_done;
    logic          push_valid;
    logic          push_ready;
    logic [QW-1:0] push_data;
    logic          q_valid;
    logic          q_ready;
    logic [QW-1:0] q_data;

    hcl_front #(
        .BUCKETS (BUCKETS),
        .BW      (BW),
        .QW      (QW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .init_done  (init_done),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .key        (key),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    hcl_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    hcl_back #(
        .BUCKETS      (BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES),
        .BW           (BW),
        .QW           (QW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .init_done (init_done),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .status    (status)
    );

endmodule

// ===== tb/set_lookup_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_lookup_checker
// Watches both channels of the hash chain set lookup and checks each reply.
// ----------------------------------------------------------------------------
// Every request transfer updates a private copy of the bucket heads and the
// node pool and queues the reply that it must produce. Every reply transfer
// is compared field by field with the oldest queued reply. Mismatches and
// unexpected replies are counted and handed to the testbench top.
module set_lookup_checker #(
    parameter int BUCKETS      = hcl_pkg::BUCKETS_DEF,
    parameter int POOL_ENTRIES = hcl_pkg::POOL_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic                      req_type,
    input  logic [hcl_pkg::KEY_W-1:0] key,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic                      found,
    input  logic                      status,
    output int                        fail_count,
    output int                        pending,
    output int                        insert_count,
    output int                        search_count,
    output int                        hit_count,
    output int                        drop_count
);

    localparam int LINK_W = $clog2(POOL_ENTRIES + 1);

    typedef struct packed {
        logic found;
        logic status;
    } reply_t;

    logic [LINK_W-1:0]         chain_heads [BUCKETS];
    logic [LINK_W-1:0]         pool_next   [POOL_ENTRIES];
    logic [hcl_pkg::KEY_W-1:0] pool_keys   [POOL_ENTRIES];
    int unsigned               pool_count;
    reply_t                    expected_replies [$];

    function automatic logic key_in_chain(input logic [hcl_pkg::KEY_W-1:0] k);
        int unsigned link;
        int unsigned steps;
        int unsigned node;
        link  = chain_heads[k % BUCKETS];
        steps = 0;
        while (link != 0 && steps < pool_count)
        begin
            node = link - 1;
            if (node >= pool_count)
                return 1'b0;
            if (pool_keys[node] == k)
                return 1'b1;
            link = pool_next[node];
            steps++;
        end
        return 1'b0;
    endfunction

    function automatic reply_t apply_request(input logic req,
                                             input logic [hcl_pkg::KEY_W-1:0] k);
        reply_t      r;
        int unsigned b;
        r = '{found: 1'b0, status: hcl_pkg::STAT_OK};
        if (req == hcl_pkg::REQ_INSERT)
        begin
            if (pool_count >= POOL_ENTRIES)
            begin
                r.status = hcl_pkg::STAT_FULL;
            end
            else
            begin
                b = k % BUCKETS;
                pool_keys[pool_count] = k;
                pool_next[pool_count] = chain_heads[b];
                chain_heads[b] = LINK_W'(pool_count + 1);
                pool_count++;
            end
        end
        else
        begin
            r.found = key_in_chain(k);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        reply_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < BUCKETS; i++)
                chain_heads[i] = '0;
            pool_count = 0;
            expected_replies.delete();
            fail_count   = 0;
            insert_count = 0;
            search_count = 0;
            hit_count    = 0;
            drop_count   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                want = apply_request(req_type, key);
                expected_replies.push_back(want);
                if (req_type == hcl_pkg::REQ_INSERT)
                    insert_count++;
                else
                    search_count++;
                if (want.found)
                    hit_count++;
                if (want.status == hcl_pkg::STAT_FULL)
                    drop_count++;
            end
            if (out_valid && out_ready)
            begin
                got = '{found: found, status: status};
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: unexpected reply, expected none, got found=%0b status=%0b",
                             $time, found, status);
                    fail_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got.found !== want.found)
                    begin
                        $display("%0t: found mismatch, expected %0b, got %0b",
                                 $time, want.found, got.found);
                        fail_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0b, got %0b",
                                 $time, want.status, got.status);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_replies.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench top of the hash chain set lookup.
// ----------------------------------------------------------------------------
// Drives a short directed sequence of inserts and searches, then about a
// thousand random requests that fill the node pool, build a long chain in one
// bucket, search for stored, neighboring and unknown keys, and keep
// inserting once the pool is full. Both sides idle at random. A separate
// checker predicts and compares every reply.
module tb;

    localparam logic [hcl_pkg::KEY_W-1:0] KEY_MAX  = {hcl_pkg::KEY_W{1'b1}};
    localparam int                        RANDOM_N = 1000;
    localparam int                        HOT_BKT  = 3;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      req_type;
    logic [hcl_pkg::KEY_W-1:0] key;
    logic                      out_valid;
    logic                      out_ready;
    logic                      found;
    logic                      status;

    int fail_count;
    int pending;
    int insert_count;
    int search_count;
    int hit_count;
    int drop_count;

    logic [hcl_pkg::KEY_W-1:0] stored_keys [$];
    bit                        steady;
    int                        inserts_sent;

    hash_chain_set_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .status    (status)
    );

    set_lookup_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .key          (key),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .status       (status),
        .fail_count   (fail_count),
        .pending      (pending),
        .insert_count (insert_count),
        .search_count (search_count),
        .hit_count    (hit_count),
        .drop_count   (drop_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int gap_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [hcl_pkg::KEY_W-1:0] pick_key();
        logic [31:0] raw;
        longint      base;
        longint      k;
        int          r;
        int          m;
        raw = $urandom;
        k   = raw[hcl_pkg::KEY_W-1:0];
        r   = $urandom_range(0, 9);
        if (stored_keys.size() != 0 && r < 4)
        begin
            k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        end
        else if (stored_keys.size() != 0 && r < 6)
        begin
            base = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            m    = $urandom_range(1, 5);
            k    = base + 10 * m;
            if (k > KEY_MAX)
                k = base - 10 * m;
        end
        else if (r == 6)
        begin
            if ($urandom_range(0, 1) == 1)
                k = $urandom_range(0, 9);
            else
                k = KEY_MAX - $urandom_range(0, 9);
        end
        return k[hcl_pkg::KEY_W-1:0];
    endfunction

    function automatic logic [hcl_pkg::KEY_W-1:0] insert_key();
        logic [31:0] raw;
        longint      k;
        if ($urandom_range(0, 9) < 6)
            return pick_key();
        raw = $urandom;
        k   = raw[hcl_pkg::KEY_W-1:0];
        if ($urandom_range(0, 1) == 1)
            k = k - (k % 10) + HOT_BKT;
        return k[hcl_pkg::KEY_W-1:0];
    endfunction

    task automatic issue(input logic req, input logic [hcl_pkg::KEY_W-1:0] k);
        int n;
        in_valid <= 1'b1;
        req_type <= req;
        key      <= k;
        do
            @(posedge clk);
        while (!in_ready);
        if (req == hcl_pkg::REQ_INSERT)
        begin
            stored_keys.push_back(k);
            inserts_sent++;
        end
        n = gap_len();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    initial
    begin
        int hold;
        hold = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (steady || $urandom_range(0, 9) < 7)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                hold = gap_len();
                out_ready <= 1'b0;
            end
        end
    end

    initial
    begin
        logic req;
        int   waited;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = hcl_pkg::REQ_INSERT;
        key          = '0;
        steady       = 1'b0;
        inserts_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(hcl_pkg::REQ_SEARCH, '0);
        issue(hcl_pkg::REQ_SEARCH, KEY_MAX);
        issue(hcl_pkg::REQ_INSERT, '0);
        issue(hcl_pkg::REQ_INSERT, KEY_MAX);
        issue(hcl_pkg::REQ_INSERT, 31'd7);
        issue(hcl_pkg::REQ_SEARCH, 31'd7);
        issue(hcl_pkg::REQ_SEARCH, KEY_MAX);
        issue(hcl_pkg::REQ_SEARCH, 31'd17);
        issue(hcl_pkg::REQ_SEARCH, '0);
        issue(hcl_pkg::REQ_SEARCH, 31'd10);
        issue(hcl_pkg::REQ_INSERT, 31'd7);
        issue(hcl_pkg::REQ_SEARCH, 31'd7);
        issue(hcl_pkg::REQ_INSERT, 31'h2AAA_AAAA);
        issue(hcl_pkg::REQ_INSERT, 31'h5555_5555);
        issue(hcl_pkg::REQ_SEARCH, 31'h2AAA_AAAA);
        issue(hcl_pkg::REQ_SEARCH, 31'h5555_5555);
        issue(hcl_pkg::REQ_SEARCH, 31'h2AAA_AAA0);
        issue(hcl_pkg::REQ_INSERT, KEY_MAX - 31'd10);
        issue(hcl_pkg::REQ_SEARCH, KEY_MAX - 31'd10);
        issue(hcl_pkg::REQ_SEARCH, KEY_MAX - 31'd20);

        for (int i = 0; i < RANDOM_N; i++)
        begin
            if (i % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (inserts_sent < hcl_pkg::POOL_DEF)
                req = ($urandom_range(0, 1) == 1) ? hcl_pkg::REQ_INSERT
                                                  : hcl_pkg::REQ_SEARCH;
            else
                req = ($urandom_range(0, 99) < 15) ? hcl_pkg::REQ_INSERT
                                                   : hcl_pkg::REQ_SEARCH;
            if (req == hcl_pkg::REQ_INSERT)
                issue(hcl_pkg::REQ_INSERT, insert_key());
            else
                issue(hcl_pkg::REQ_SEARCH, pick_key());
        end
        in_valid <= 1'b0;
        steady = 1'b0;

        waited = 0;
        while (pending != 0 && waited < 50_000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);

        if (pending != 0)
            $display("%0t: %0d expected replies never arrived", $time, pending);
        $display("Run covered %0d transfers: %0d inserts, %0d of them dropped on a full pool,",
                 insert_count + search_count, insert_count, drop_count);
        $display("and %0d searches, %0d of which found their key.", search_count, hit_count);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
